>>> hdl/bia_pkg.sv
package bia_pkg;

	localparam int MAP_DEPTH = 4096;
	localparam int MAP_W     = $clog2(MAP_DEPTH);
	localparam int ID_W      = 32;
	localparam int CNT_W     = 13;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;

	localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

	localparam logic OP_REGISTER = 1'b0;
	localparam logic OP_GENERATE = 1'b1;

	localparam logic REG_TRACKED_COUNT = 1'b0;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_STEP  = 4'b0100,
		ST_CHECK = 4'b1000
	} state_t;

	typedef struct packed {
		logic clear_wr;
		logic accept_reg;
		logic accept_gen;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic at_max;
		logic next_in_range;
		logic map_bit;
	} status_t;

endpackage

>>> hdl/bia_ram.sv
module bia_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/bia_ctrl.sv
module bia_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             op,
	input  bia_pkg::status_t status,
	output bia_pkg::cmd_t    cmd,
	output logic             busy
);

	import bia_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (op == OP_REGISTER) begin
						cmd.accept_reg = 1'b1;
					end else begin
						cmd.accept_gen = 1'b1;
						state_d        = ST_STEP;
					end
				end
			end
			ST_STEP: begin
				if (status.at_max) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.step = 1'b1;
					if (status.next_in_range) begin
						state_d = ST_CHECK;
					end else begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			ST_CHECK: begin
				// used mark: keep scanning, else stop on this candidate
				if (status.map_bit) begin
					state_d = ST_STEP;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> hdl/bia_dp.sv
module bia_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bia_pkg::cmd_t             cmd,
	output bia_pkg::status_t          status,
	input  logic [bia_pkg::CNT_W-1:0] tracked_count,
	input  logic [bia_pkg::ID_W-1:0]  instance_id,
	output logic [bia_pkg::ID_W-1:0]  new_id,
	output logic                      overflow,
	output logic                      range_error,
	output logic                      done
);

	import bia_pkg::*;

	logic [ID_W-1:0]  cand_q, cand_d, cand_inc;
	logic [ID_W-1:0]  gen_id_q;
	logic [ID_W-1:0]  eff_count, tc_ext;
	logic [MAP_W-1:0] clr_q;
	logic             id_in_range;
	logic             ram_we;
	logic [MAP_W-1:0] ram_waddr;
	logic             ram_wdata;
	logic             ram_rdata;

	assign tc_ext    = ID_W'(tracked_count);
	assign eff_count = (tc_ext > ID_W'(MAP_DEPTH)) ? ID_W'(MAP_DEPTH) : tc_ext;
	assign cand_inc  = cand_q + 1'b1;

	assign id_in_range = (instance_id < eff_count);

	always_comb begin
		cand_d = cand_q;
		if (cmd.accept_reg) begin
			if (cand_q == instance_id && cand_q != ID_MAX) begin
				cand_d = cand_inc;
			end
		end else if (cmd.step) begin
			cand_d = cand_inc;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 1'b0;
		if (cmd.clear_wr) begin
			ram_we = 1'b1;
		end else if (cmd.accept_reg && id_in_range) begin
			ram_we    = 1'b1;
			ram_waddr = instance_id[MAP_W-1:0];
			ram_wdata = 1'b1;
		end
	end

	bia_ram #(
		.WIDTH(1),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cand_inc[MAP_W-1:0]),
		.rdata (ram_rdata)
	);

	assign status.clear_last    = (clr_q == MAP_W'(MAP_DEPTH - 1));
	assign status.at_max        = (cand_q == ID_MAX);
	assign status.next_in_range = (cand_inc < eff_count);
	assign status.map_bit       = ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= ID_W'(1);
			clr_q  <= '0;
			done   <= 1'b0;
		end else begin
			cand_q <= cand_d;
			done   <= cmd.accept_reg | cmd.finish;
			if (cmd.clear_wr) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_gen) begin
			gen_id_q <= cand_q;
		end
		if (cmd.accept_reg) begin
			new_id      <= cand_d;
			overflow    <= (cand_d == ID_MAX);
			range_error <= ~id_in_range;
		end else if (cmd.finish) begin
			new_id      <= gen_id_q;
			overflow    <= (cand_d == ID_MAX);
			range_error <= 1'b0;
		end
	end

endmodule

>>> hdl/bitmap_id_allocator.sv
// Register transaction: result strobe (done) in the cycle after start is taken; busy stays low.
// Generate transaction: the scan steps past each used id with a bitmap RAM read (ST_STEP) and
//   a decision (ST_CHECK), and stops on a free id, when it leaves the tracked range or when the
//   candidate sits at the maximum; busy drops as done rises.
// Reset: the 4096-entry bitmap is cleared one entry per cycle with busy high;
//   the candidate resets to 1 and tracked_count to 0. The receiver cannot stall.
module bitmap_id_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bia_pkg::ADDR_W-1:0] paddr,
	input  logic [bia_pkg::DATA_W-1:0] pwdata,
	output logic [bia_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	// command channel
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic [bia_pkg::ID_W-1:0]   instance_id,
	// result channel
	output logic                       done,
	output logic [bia_pkg::ID_W-1:0]   new_id,
	output logic                       overflow,
	output logic                       range_error
);

	import bia_pkg::*;

	logic [CNT_W-1:0] tracked_count_q;
	logic             cfg_wr;
	cmd_t             cmd;
	status_t          status;

	// Single register at word 0; decode on the word bit of the address only.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_count_q <= '0;
		end else if (cfg_wr && paddr[ADDR_W-1] == REG_TRACKED_COUNT) begin
			tracked_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1] == REG_TRACKED_COUNT) begin
			prdata = DATA_W'(tracked_count_q);
		end
	end

	// Controller sequences the clear sweep and the generate scan; the
	// datapath holds the candidate, the bitmap RAM and the result registers.
	bia_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	bia_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.tracked_count (tracked_count_q),
		.instance_id   (instance_id),
		.new_id        (new_id),
		.overflow      (overflow),
		.range_error   (range_error),
		.done          (done)
	);

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import bia_pkg::*;

	// One requested transaction, as the driver puts it on the command channel.
	typedef struct packed {
		logic            op;
		logic [ID_W-1:0] id;
	} alloc_req_t;

	// One result transaction, as the allocator should report it.
	typedef struct packed {
		logic [ID_W-1:0] new_id;
		logic            overflow;
		logic            range_error;
	} alloc_rsp_t;

	localparam logic [ADDR_W-1:0] TRACKED_COUNT_ADDR = ADDR_W'(REG_TRACKED_COUNT) << 2;
	localparam int PHASE_ITEMS = 150;
	localparam int DRAIN_CYCLES = 20;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [ADDR_W-1:0] paddr       = '0;
	logic [DATA_W-1:0] pwdata      = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              start       = 1'b0;
	logic              busy;
	logic              op          = OP_REGISTER;
	logic [ID_W-1:0]   instance_id = '0;
	logic              done;
	logic [ID_W-1:0]   new_id;
	logic              overflow;
	logic              range_error;

	bitmap_id_allocator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.instance_id (instance_id),
		.done        (done),
		.new_id      (new_id),
		.overflow    (overflow),
		.range_error (range_error)
	);

	initial begin : clock_gen
		forever #5 clk = ~clk;
	end

	// Shadow state of the allocator: used marks, next candidate and the programmed count.
	bit              used_bits [MAP_DEPTH];
	logic [ID_W-1:0] candidate   = 1;
	logic [CNT_W-1:0] model_count = '0;

	alloc_req_t pending_reqs[$];     // transactions waiting for the driver
	alloc_rsp_t expected_results[$]; // results owed by the allocator, oldest first

	int unsigned n_errors     = 0;
	int unsigned n_queued     = 0;
	int unsigned n_items      = 0;
	int unsigned n_register   = 0;
	int unsigned n_generate   = 0;
	int unsigned n_range_err  = 0;
	int unsigned n_results    = 0;
	int unsigned n_settings   = 0;
	int unsigned longest_scan = 0;
	int unsigned gap_cycles   = 0;
	int unsigned calm_left    = 0;

	task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
			input logic [ID_W-1:0] want);
		n_errors++;
		$display("%0t ns  MISMATCH %s: got %h, want %h", $time, what, got, want);
	endtask

	// Apply one accepted transaction to the shadow state and return the result it owes.
	function automatic alloc_rsp_t allocate_step(input logic req_op, input logic [ID_W-1:0] req_id);
		alloc_rsp_t  rsp;
		int unsigned lim;
		int unsigned steps;
		lim = (model_count > MAP_DEPTH) ? MAP_DEPTH : model_count;
		rsp.range_error = 1'b0;
		steps = 0;
		if (req_op == OP_REGISTER) begin
			n_register++;
			if (req_id < lim)
				used_bits[req_id[MAP_W-1:0]] = 1'b1;
			else
				rsp.range_error = 1'b1;
			// the candidate rule holds even for an out-of-range id; saturate at the maximum
			if (candidate == req_id && candidate != ID_MAX)
				candidate++;
			rsp.new_id = candidate;
		end else begin
			n_generate++;
			rsp.new_id = candidate;
			// advance at least once unless at the maximum, then skip used marks inside the tracked range only
			while (candidate < ID_MAX) begin
				candidate++;
				steps++;
				if (!(candidate < lim && used_bits[candidate[MAP_W-1:0]]))
					break;
			end
			if (steps > longest_scan)
				longest_scan = steps;
		end
		rsp.overflow = (candidate == ID_MAX);
		if (rsp.range_error)
			n_range_err++;
		return rsp;
	endfunction

	// Pick the pause before the next transaction; runs of back-to-back traffic come now and then.
	function automatic int unsigned draw_gap();
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	// Driver: hold start until busy drops, then predict the accepted transaction and
	// advance to the next pending one after the drawn gap.
	always @(posedge clk or negedge arst_n) begin : drive_requests
		alloc_req_t req;
		if (!arst_n) begin
			start       <= 1'b0;
			op          <= OP_REGISTER;
			instance_id <= '0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(allocate_step(op, instance_id));
				n_items++;
				gap_cycles = draw_gap();
			end
			if (!(start && busy)) begin
				if (gap_cycles > 0) begin
					start <= 1'b0;
					gap_cycles--;
				end else if (pending_reqs.size() > 0) begin
					req = pending_reqs.pop_front();
					start       <= 1'b1;
					op          <= req.op;
					instance_id <= req.id;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done cycle carries one result; match it against the oldest expectation.
	always @(posedge clk) begin : check_results
		alloc_rsp_t want;
		if (arst_n && done) begin
			n_results++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, new_id", new_id, '0);
			end else begin
				want = expected_results.pop_front();
				if (new_id !== want.new_id)
					report_mismatch("new_id", new_id, want.new_id);
				if (overflow !== want.overflow)
					report_mismatch("overflow", ID_W'(overflow), ID_W'(want.overflow));
				if (range_error !== want.range_error)
					report_mismatch("range_error", ID_W'(range_error), ID_W'(want.range_error));
			end
		end
	end

	function automatic void push_req(input logic req_op, input logic [ID_W-1:0] req_id);
		pending_reqs.push_back('{op: req_op, id: req_id});
		n_queued++;
	endfunction

	// Write tracked_count through the config port, then read it back. Upper data bits are junk.
	task automatic set_tracked_count(input logic [CNT_W-1:0] value);
		logic [DATA_W-1:0] word;
		word = $urandom;
		word[CNT_W-1:0] = value;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TRACKED_COUNT_ADDR;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		model_count = value;
		n_settings++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CNT_W-1:0] !== model_count)
			report_mismatch("tracked_count readback", ID_W'(prdata[CNT_W-1:0]), ID_W'(model_count));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Wait until the driver has nothing left and every result has come back.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || start || expected_results.size() != 0 || busy);
	endtask

	// Queue one random sequence. Most are well formed: mark a run of ids just ahead of the
	// candidate, then generate across it. The rest are single requests, mostly at random ids.
	task automatic queue_sequence();
		int unsigned kind;
		int unsigned len;
		int unsigned lim;
		logic [ID_W-1:0] base;
		bit reverse;
		kind = $urandom_range(0, 99);
		lim  = (model_count > MAP_DEPTH) ? MAP_DEPTH : model_count;
		if (kind < 55) begin
			len     = $urandom_range(1, 12);
			base    = candidate + $urandom_range(0, 3);
			reverse = $urandom_range(0, 1);
			for (int k = 0; k < len; k++)
				push_req(OP_REGISTER, reverse ? base + len - 1 - k : base + k);
			repeat ($urandom_range(1, 2))
				push_req(OP_GENERATE, $urandom);
		end else if (kind < 70) begin
			push_req(OP_REGISTER, candidate);
		end else if (kind < 80) begin
			push_req(OP_GENERATE, $urandom);
		end else if (kind < 88) begin
			push_req(OP_REGISTER, $urandom);
		end else if (kind < 94) begin
			push_req(OP_REGISTER, $urandom_range(0, MAP_DEPTH - 1));
		end else begin
			// straddle the edge of the tracked range
			push_req(OP_REGISTER, ID_W'(lim) - 1 + $urandom_range(0, 2));
		end
	endtask

	task automatic run_random_phase(input logic [CNT_W-1:0] count_value, input int unsigned n);
		int unsigned target;
		set_tracked_count(count_value);
		target = n_queued + n;
		while (n_queued < target) begin
			@(negedge clk);
			if (pending_reqs.size() == 0)
				queue_sequence();
		end
		wait_drained();
	endtask

	initial begin : run_stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// hold off until the bitmap clearing pass after reset is over
		wait_drained();

		// Small tracked range: candidate advance, skip over marks, range edges, scan past count.
		set_tracked_count(13'd8);
		@(negedge clk);
		push_req(OP_REGISTER, 32'd0);
		push_req(OP_REGISTER, 32'd1);          // equals the candidate: advance
		push_req(OP_REGISTER, 32'd3);
		push_req(OP_REGISTER, 32'd4);
		push_req(OP_GENERATE, ID_MAX);         // id field ignored; skip both marks
		push_req(OP_REGISTER, 32'd7);          // last tracked id
		push_req(OP_REGISTER, 32'd8);          // first id past the range
		push_req(OP_REGISTER, ID_MAX);
		push_req(OP_REGISTER, 32'h8000_0000);
		push_req(OP_GENERATE, 32'd0);
		push_req(OP_REGISTER, 32'd6);
		push_req(OP_GENERATE, 32'h5555_5555);  // scan stops at the count
		push_req(OP_GENERATE, 32'hAAAA_AAAA);  // candidate already past the count
		push_req(OP_REGISTER, 32'd9);          // out of range, still advances the candidate
		push_req(OP_REGISTER, 32'h5555_5555);
		push_req(OP_REGISTER, 32'hAAAA_AAAA);
		wait_drained();

		// Nothing tracked at all.
		set_tracked_count(13'd0);
		@(negedge clk);
		push_req(OP_REGISTER, 32'd0);
		push_req(OP_GENERATE, 32'd0);
		push_req(OP_REGISTER, 32'd11);
		wait_drained();

		// Count above the bitmap depth saturates to the depth.
		set_tracked_count(13'h1FFF);
		@(negedge clk);
		push_req(OP_REGISTER, 32'd4095);
		push_req(OP_REGISTER, 32'd4096);
		push_req(OP_REGISTER, 32'd13);
		push_req(OP_REGISTER, 32'd14);
		push_req(OP_GENERATE, 32'd0);
		wait_drained();

		// The all-ones candidate cannot be reached in a bounded run; the shadow model
		// still carries the saturation rules so any early overflow shows up as a mismatch.
		run_random_phase(13'd4096, PHASE_ITEMS);
		run_random_phase(13'd1, PHASE_ITEMS);
		run_random_phase(CNT_W'($urandom_range(0, 8191)), PHASE_ITEMS);
		run_random_phase(13'd5000, PHASE_ITEMS);
		run_random_phase(CNT_W'($urandom_range(0, MAP_DEPTH)), PHASE_ITEMS);
		run_random_phase(13'd4096, PHASE_ITEMS);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never returned", ID_W'(expected_results.size()), '0);

		$display("Run: %0d transactions (%0d register, %0d generate), %0d results checked.",
			n_items, n_register, n_generate, n_results);
		$display("     %0d range errors, longest generate scan %0d steps, %0d count settings.",
			n_range_err, longest_scan, n_settings);
		if (n_errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Drop the run if the allocator hangs.
	initial begin : watchdog
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
